>>> rtl/core/iorb_pkg.sv
// shared constants, status codes and slot arithmetic for the in-order reorder buffer
package iorb_pkg;

  // number of entries in the buffer
  localparam int DEPTH = 32;

  // entry index and occupancy widths
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = OCC_W + 1;

  // field widths
  localparam int START_W  = 32;
  localparam int LEN_W    = 12;
  localparam int HANDLE_W = 32;
  localparam int FREE_W   = 7;
  localparam int ENTRY_W  = START_W + LEN_W + HANDLE_W;

  // item kinds
  localparam logic REQ_NEW  = 1'b0;
  localparam logic REQ_RESP = 1'b1;

  // result status codes
  localparam logic [1:0] ST_QUEUED    = 2'd0;
  localparam logic [1:0] ST_MATCHED   = 2'd1;
  localparam logic [1:0] ST_UNMATCHED = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // circular slot index: base plus offset, wrapped at the buffer depth
  function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
                                                 input logic [OCC_W-1:0]  offs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offs);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

>>> rtl/core/in_order_reorder_buffer_unit.sv
// in-order reorder buffer: request entries, response matching, in-order retirement
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------------
//   in       | in_valid, in_stall | req_type, seg_start, seg_length, payload_handle
//   out      | out_valid, out_stall | status, has_record, out_start, out_length,
//            |                    | out_payload, free_slots, is_empty, last
//
// a request's result is loaded into the output register at accept.
// a response scans occupied entries from the head through one ram read port, one entry
// per cycle, then counts filled head entries one per cycle, then retires each one
// with a ram read, then an output load, or loads its single result; each output load
// waits while the output is stalled.
// reset (rst, synchronous) empties the buffer; only the state, filled bits, pointers,
// scan position, compare valid and the output valid are cleared.
// in_stall is high while an item is in progress or the output register cannot load.
module in_order_reorder_buffer_unit
  import iorb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic [START_W-1:0]  seg_start,
  input  logic [LEN_W-1:0]    seg_length,
  input  logic [HANDLE_W-1:0] payload_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic                has_record,
  output logic [START_W-1:0]  out_start,
  output logic [LEN_W-1:0]    out_length,
  output logic [HANDLE_W-1:0] out_payload,
  output logic [FREE_W-1:0]   free_slots,
  output logic                is_empty,
  output logic                last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COUNT,
    S_RD,
    S_RET,
    S_DONE
  } state_t;

  localparam logic [FREE_W-1:0] DEPTH_F = FREE_W'(DEPTH);
  localparam logic [OCC_W-1:0]  DEPTH_O = OCC_W'(DEPTH);
  localparam logic [OCC_W-1:0]  ONE_O   = OCC_W'(1);

  state_t              state;
  logic [ADDR_W-1:0]   head;
  logic [OCC_W-1:0]    occ;
  logic [DEPTH-1:0]    filled;
  logic [OCC_W-1:0]    pos;
  logic                cmp_v;
  logic [ADDR_W-1:0]   cmp_slot;
  logic [1:0]          done_status;
  logic [FREE_W-1:0]   fin_free;
  logic                fin_empty;
  logic [START_W-1:0]  it_start;
  logic [LEN_W-1:0]    it_len;
  logic [HANDLE_W-1:0] it_handle;

  logic                out_free;
  logic                out_load;
  logic                accept;
  logic                req_ok;
  logic                hit;
  logic [ADDR_W-1:0]   tail;
  logic [ADDR_W-1:0]   scan_slot;
  logic [ADDR_W-1:0]   count_slot;
  logic [OCC_W-1:0]    occ_left;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0]  rd_data;
  logic [START_W-1:0]  rd_start;
  logic [LEN_W-1:0]    rd_len;
  logic [HANDLE_W-1:0] rd_handle;

  // handshake and slot positions
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = !((state == S_IDLE) && out_free);
  assign accept     = in_valid && !in_stall;
  assign req_ok     = (occ < DEPTH_O);
  assign tail       = slot_add(head, occ);
  assign scan_slot  = slot_add(head, pos);
  assign count_slot = slot_add(head, pos);
  assign occ_left   = occ - pos;

  // output register loads a new result this cycle
  assign out_load = (accept && (req_type == REQ_NEW)) ||
                    (((state == S_RET) || (state == S_DONE)) && out_free);

  // entry fields from the ram
  assign rd_start  = rd_data[ENTRY_W-1 -: START_W];
  assign rd_len    = rd_data[HANDLE_W +: LEN_W];
  assign rd_handle = rd_data[HANDLE_W-1:0];

  // match of the entry read in the previous cycle
  assign hit = (state == S_SCAN) && cmp_v && !filled[cmp_slot] &&
               (rd_start == it_start) && (rd_len == it_len);

  // ram write: new request at the tail, or payload fill on match
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail;
    wr_data = {seg_start, seg_length, HANDLE_W'(0)};
    if (state == S_IDLE) begin
      wr_en = accept && (req_type == REQ_NEW) && req_ok;
    end else if (hit) begin
      wr_en   = 1'b1;
      wr_addr = cmp_slot;
      wr_data = {it_start, it_len, it_handle};
    end
  end

  // ram read: scan walk or head entry for retirement
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    if (state == S_SCAN) begin
      rd_en   = (pos < occ);
      rd_addr = scan_slot;
    end else if (state == S_RD) begin
      rd_en = 1'b1;
    end
  end

  iorb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer, buffer pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      occ       <= '0;
      filled    <= '0;
      pos       <= '0;
      cmp_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            it_start  <= seg_start;
            it_len    <= seg_length;
            it_handle <= payload_handle;
            if (req_type == REQ_NEW) begin
              // request result is known at once
              has_record  <= 1'b0;
              out_start   <= '0;
              out_length  <= '0;
              out_payload <= '0;
              last        <= 1'b1;
              if (req_ok) begin
                filled[tail] <= 1'b0;
                occ          <= occ + ONE_O;
                status       <= ST_QUEUED;
                free_slots   <= DEPTH_F - FREE_W'(occ) - FREE_W'(1);
                is_empty     <= 1'b0;
              end else begin
                status     <= ST_FULL;
                free_slots <= DEPTH_F - FREE_W'(occ);
                is_empty   <= (occ == '0);
              end
            end else begin
              pos   <= '0;
              cmp_v <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // walk oldest to newest, compare in the cycle after the read
          cmp_v    <= (pos < occ);
          cmp_slot <= scan_slot;
          if (hit) begin
            filled[cmp_slot] <= 1'b1;
            pos              <= '0;
            state            <= S_COUNT;
          end else begin
            if (pos < occ) begin
              pos <= pos + ONE_O;
            end
            if (pos == occ) begin
              done_status <= ST_UNMATCHED;
              state       <= S_DONE;
            end
          end
        end
        S_COUNT: begin
          // count the run of filled entries at the head
          if ((pos < occ) && filled[count_slot]) begin
            pos <= pos + ONE_O;
          end else if (pos == '0) begin
            done_status <= ST_MATCHED;
            state       <= S_DONE;
          end else begin
            fin_free  <= DEPTH_F - FREE_W'(occ_left);
            fin_empty <= (occ_left == '0);
            state     <= S_RD;
          end
        end
        S_RD: begin
          state <= S_RET;
        end
        S_RET: begin
          // retire the head entry
          if (out_free) begin
            status       <= ST_MATCHED;
            has_record   <= 1'b1;
            out_start    <= rd_start;
            out_length   <= rd_len;
            out_payload  <= rd_handle;
            free_slots   <= fin_free;
            is_empty     <= fin_empty;
            last         <= (pos == ONE_O);
            filled[head] <= 1'b0;
            head         <= slot_add(head, ONE_O);
            occ          <= occ - ONE_O;
            pos          <= pos - ONE_O;
            state        <= (pos == ONE_O) ? S_IDLE : S_RD;
          end
        end
        S_DONE: begin
          // single result without a record
          if (out_free) begin
            status      <= done_status;
            has_record  <= 1'b0;
            out_start   <= '0;
            out_length  <= '0;
            out_payload <= '0;
            free_slots  <= DEPTH_F - FREE_W'(occ);
            is_empty    <= (occ == '0);
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/iorb_ram.sv
// generic single-write, single-read ram with registered read data
module iorb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, data holds while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sim/tb_in_order_reorder_buffer_unit.sv
// testbench for the in-order reorder buffer: directed table, random traffic, result checks
`timescale 1ns / 100ps

module tb_in_order_reorder_buffer_unit
  import iorb_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 120;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 85;
  localparam int DIR_ROWS       = 15;

  // one input item
  typedef struct packed {
    logic                req_type;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    len;
    logic [HANDLE_W-1:0] handle;
  } seg_item_t;

  // one result item
  typedef struct packed {
    logic [1:0]          status;
    logic                has_record;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    len;
    logic [HANDLE_W-1:0] payload;
    logic [FREE_W-1:0]   free;
    logic                empty;
    logic                last;
  } seg_result_t;

  // directed row: item plus a hand-written single result where it is obvious
  typedef struct packed {
    seg_item_t         item;
    logic              typed;
    logic [1:0]        status;
    logic [FREE_W-1:0] free;
    logic              empty;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                req_type;
  logic [START_W-1:0]  seg_start;
  logic [LEN_W-1:0]    seg_length;
  logic [HANDLE_W-1:0] payload_handle;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          status;
  logic                has_record;
  logic [START_W-1:0]  out_start;
  logic [LEN_W-1:0]    out_length;
  logic [HANDLE_W-1:0] out_payload;
  logic [FREE_W-1:0]   free_slots;
  logic                is_empty;
  logic                last;

  in_order_reorder_buffer_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .seg_start      (seg_start),
    .seg_length     (seg_length),
    .payload_handle (payload_handle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .has_record     (has_record),
    .out_start      (out_start),
    .out_length     (out_length),
    .out_payload    (out_payload),
    .free_slots     (free_slots),
    .is_empty       (is_empty),
    .last           (last)
  );

  // shadow copy of the buffer contents
  logic [START_W-1:0]  rob_start  [DEPTH];
  logic [LEN_W-1:0]    rob_len    [DEPTH];
  logic [HANDLE_W-1:0] rob_handle [DEPTH];
  logic                rob_filled [DEPTH];
  int                  rob_head;
  int                  rob_occ;

  seg_result_t step_results [$];
  seg_result_t due_results  [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int err_cnt        = 0;
  int n_items        = 0;
  int n_results      = 0;
  int n_records      = 0;
  int n_queued       = 0;
  int n_full         = 0;
  int n_unmatched    = 0;
  int max_burst      = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // unmatched response right after reset
    '{'{REQ_RESP, 32'h0, 12'h0, 32'h0}, 1'b1, ST_UNMATCHED, FREE_W'(DEPTH), 1'b1},
    // requests at the field extremes, plus a duplicate key
    '{'{REQ_NEW, 32'hFFFF_FFFF, 12'hFFF, 32'h0}, 1'b1, ST_QUEUED, FREE_W'(DEPTH - 1), 1'b0},
    '{'{REQ_NEW, 32'h0, 12'h0, 32'hFFFF_FFFF}, 1'b1, ST_QUEUED, FREE_W'(DEPTH - 2), 1'b0},
    '{'{REQ_NEW, 32'h0, 12'h0, 32'h0}, 1'b1, ST_QUEUED, FREE_W'(DEPTH - 3), 1'b0},
    '{'{REQ_NEW, 32'h1234_5678, 12'h800, 32'h0}, 1'b1, ST_QUEUED, FREE_W'(DEPTH - 4), 1'b0},
    // duplicate key: only the oldest copy gets filled
    '{'{REQ_RESP, 32'h0, 12'h0, 32'hFFFF_FFFF}, 1'b0, ST_QUEUED, '0, 1'b0},
    // start matches, length does not
    '{'{REQ_RESP, 32'hFFFF_FFFF, 12'h0, 32'h1}, 1'b1, ST_UNMATCHED, FREE_W'(DEPTH - 4), 1'b0},
    '{'{REQ_RESP, 32'h1234_5678, 12'h800, 32'hA5A5_A5A5}, 1'b0, ST_QUEUED, '0, 1'b0},
    '{'{REQ_RESP, 32'h0, 12'h0, 32'h0}, 1'b0, ST_QUEUED, '0, 1'b0},
    // head filled last: whole buffer retires in one burst
    '{'{REQ_RESP, 32'hFFFF_FFFF, 12'hFFF, 32'h0}, 1'b0, ST_QUEUED, '0, 1'b0},
    '{'{REQ_RESP, 32'h0, 12'h0, 32'h7}, 1'b1, ST_UNMATCHED, FREE_W'(DEPTH), 1'b1},
    '{'{REQ_NEW, 32'h8000_0000, 12'h001, 32'h0}, 1'b1, ST_QUEUED, FREE_W'(DEPTH - 1), 1'b0},
    '{'{REQ_RESP, 32'h8000_0000, 12'h001, 32'h5A5A_5A5A}, 1'b0, ST_QUEUED, '0, 1'b0},
    '{'{REQ_NEW, 32'h0000_0001, 12'h7FF, 32'hFFFF_FFFF}, 1'b1, ST_QUEUED, FREE_W'(DEPTH - 1),
      1'b0},
    // zero payload handle retires like any other
    '{'{REQ_RESP, 32'h0000_0001, 12'h7FF, 32'h0}, 1'b0, ST_QUEUED, '0, 1'b0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // expected results of one accepted item, state updated in place
  function automatic void step_buffer(input seg_item_t it);
    seg_result_t r;
    int          p;
    int          s;
    bit          found;
    step_results.delete();
    r = '0;
    if (it.req_type == REQ_NEW) begin
      if (rob_occ >= DEPTH) begin
        r.status = ST_FULL;
        step_results.push_back(r);
        n_full++;
      end else begin
        s = (rob_head + rob_occ) % DEPTH;
        rob_start[s]  = it.start;
        rob_len[s]    = it.len;
        rob_handle[s] = '0;
        rob_filled[s] = 1'b0;
        rob_occ++;
        r.status = ST_QUEUED;
        step_results.push_back(r);
        n_queued++;
      end
    end else begin
      found = 1'b0;
      for (p = 0; p < rob_occ && !found; p++) begin
        s = (rob_head + p) % DEPTH;
        if (!rob_filled[s] && rob_start[s] == it.start && rob_len[s] == it.len) begin
          rob_handle[s] = it.handle;
          rob_filled[s] = 1'b1;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.status = ST_UNMATCHED;
        step_results.push_back(r);
        n_unmatched++;
      end else begin
        // retire filled entries from the head
        while (rob_occ > 0 && rob_filled[rob_head]) begin
          r.status     = ST_MATCHED;
          r.has_record = 1'b1;
          r.start      = rob_start[rob_head];
          r.len        = rob_len[rob_head];
          r.payload    = rob_handle[rob_head];
          step_results.push_back(r);
          rob_filled[rob_head] = 1'b0;
          rob_head = (rob_head + 1) % DEPTH;
          rob_occ--;
        end
        if (step_results.size() > max_burst) max_burst = step_results.size();
        if (step_results.size() == 0) begin
          r = '0;
          r.status = ST_MATCHED;
          step_results.push_back(r);
        end
      end
    end
    foreach (step_results[i]) begin
      step_results[i].free  = FREE_W'(DEPTH - rob_occ);
      step_results[i].empty = (rob_occ == 0);
      step_results[i].last  = (i == step_results.size() - 1);
    end
  endfunction

  // random item, mostly responses to outstanding requests
  function automatic seg_item_t gen_item();
    seg_item_t it;
    int        open_pos [$];
    int        r;
    int        p;
    int        s;
    it.req_type = REQ_NEW;
    it.start    = $urandom;
    it.len      = LEN_W'($urandom);
    it.handle   = $urandom;
    if ($urandom_range(9) == 0) it.start = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(9) == 0) it.len = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(9) == 0) it.handle = $urandom_range(1) ? '1 : '0;
    for (p = 0; p < rob_occ; p++) begin
      s = (rob_head + p) % DEPTH;
      if (!rob_filled[s]) open_pos.push_back(s);
    end
    r = $urandom_range(99);
    if ((r < 45 && rob_occ < DEPTH - 2) || (open_pos.size() == 0 && rob_occ < DEPTH)) begin
      // new request, now and then repeating an outstanding key
      if (rob_occ > 0 && $urandom_range(6) == 0) begin
        s = (rob_head + $urandom_range(rob_occ - 1)) % DEPTH;
        it.start = rob_start[s];
        it.len   = rob_len[s];
      end
    end else if (r < 88 && open_pos.size() > 0) begin
      // well-formed response, often for the head so entries retire
      it.req_type = REQ_RESP;
      s = ($urandom_range(2) == 0) ? open_pos[0] : open_pos[$urandom_range(open_pos.size() - 1)];
      it.start = rob_start[s];
      it.len   = rob_len[s];
    end else begin
      // noise: stray key, or a near miss on a held entry
      it.req_type = REQ_RESP;
      if (rob_occ > 0 && $urandom_range(1) == 1) begin
        s = (rob_head + $urandom_range(rob_occ - 1)) % DEPTH;
        it.start = rob_start[s];
        it.len   = rob_len[s];
        if ($urandom_range(1) == 1) it.len = it.len ^ (LEN_W'(1) << $urandom_range(LEN_W - 1));
        else it.start = it.start ^ (START_W'(1) << $urandom_range(START_W - 1));
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // drive one item at a falling edge, wait for accept, then maybe idle
  task automatic offer(input seg_item_t it, input bit use_typed, input seg_result_t typed_res);
    in_valid       <= 1'b1;
    req_type       <= it.req_type;
    seg_start      <= it.start;
    seg_length     <= it.len;
    payload_handle <= it.handle;
    do @(posedge clk); while (in_stall);
    step_buffer(it);
    n_items++;
    if (use_typed) due_results.push_back(typed_res);
    else foreach (step_results[i]) due_results.push_back(step_results[i]);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // sender pauses until every expected result has come
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    @(negedge clk);
  endtask

  // answer the head entry until the buffer is empty
  task automatic flush_entries();
    seg_item_t it;
    while (rob_occ > 0) begin
      it.req_type = REQ_RESP;
      it.start    = rob_start[rob_head];
      it.len      = rob_len[rob_head];
      it.handle   = $urandom;
      offer(it, 1'b0, '0);
    end
  endtask

  // receiver: random stall, or a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    seg_result_t got;
    seg_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, has_record, out_start, out_length, out_payload, free_slots, is_empty, last};
      n_results++;
      if (got.has_record) n_records++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", got));
      end else begin
        want = due_results.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.has_record !== want.has_record)
          report_mismatch($sformatf("has_record %0b, expected %0b", got.has_record,
                                    want.has_record));
        if (got.start !== want.start)
          report_mismatch($sformatf("out_start %h, expected %h", got.start, want.start));
        if (got.len !== want.len)
          report_mismatch($sformatf("out_length %h, expected %h", got.len, want.len));
        if (got.payload !== want.payload)
          report_mismatch($sformatf("out_payload %h, expected %h", got.payload, want.payload));
        if (got.free !== want.free)
          report_mismatch($sformatf("free_slots %0d, expected %0d", got.free, want.free));
        if (got.empty !== want.empty)
          report_mismatch($sformatf("is_empty %0b, expected %0b", got.empty, want.empty));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // main sequence
  initial begin
    seg_item_t   it;
    seg_result_t tr;
    seg_item_t   keys [$];
    int          order [$];
    int          i;
    int          j;
    int          tmp;

    rst            = 1'b1;
    in_valid       = 1'b0;
    req_type       = REQ_NEW;
    seg_start      = '0;
    seg_length     = '0;
    payload_handle = '0;
    rob_head       = 0;
    rob_occ        = 0;
    foreach (rob_filled[k]) rob_filled[k] = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (i = 0; i < DIR_ROWS; i++) begin
      tr = '0;
      tr.status = dir_tab[i].status;
      tr.free   = dir_tab[i].free;
      tr.empty  = dir_tab[i].empty;
      tr.last   = 1'b1;
      offer(dir_tab[i].item, dir_tab[i].typed, tr);
    end
    wait_drain();

    // long receiver hold-off while the sender keeps offering
    hold_left = HOLD_CYCLES;
    for (i = 0; i < 20; i++) offer(gen_item(), 1'b0, '0);
    wait_drain();

    // fill to full, overflow twice, then answer out of order with the head last
    flush_entries();
    for (i = 0; i < DEPTH + 2; i++) begin
      it.req_type = REQ_NEW;
      it.start    = $urandom;
      it.len      = LEN_W'($urandom);
      it.handle   = $urandom;
      keys.push_back(it);
      offer(it, 1'b0, '0);
    end
    for (i = 1; i < DEPTH; i++) order.push_back(i);
    for (i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    order.push_back(0);
    foreach (order[k]) begin
      it = keys[order[k]];
      it.req_type = REQ_RESP;
      it.handle   = $urandom;
      offer(it, 1'b0, '0);
    end
    wait_drain();

    // random phases with different idling
    for (i = 0; i < 4; i++) begin
      case (i)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (j = 0; j < PHASE_ITEMS; j++) offer(gen_item(), 1'b0, '0);
      if (i == 1) wait_drain();
    end
    flush_entries();

    // wind down
    in_valid <= 1'b0;
    recv_stall_pct = 20;
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));

    $display("covered %0d items and %0d results, %0d of them retired entries",
             n_items, n_results, n_records);
    $display("%0d queued, %0d dropped on full, %0d unmatched, longest retire burst %0d",
             n_queued, n_full, n_unmatched, max_burst);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/iorb_pkg.sv
rtl/core/iorb_ram.sv
rtl/core/in_order_reorder_buffer_unit.sv
sim/tb_in_order_reorder_buffer_unit.sv
